// ===== rtl/mpad_pkg.sv =====
// ----------------------------------------------------------------------------
// mpad_pkg
// Shared types, sizes and register codes for the min-plus machine assignment
// datapath.
// ----------------------------------------------------------------------------
package mpad_pkg;

    localparam int MACHINES       = 4;
    localparam int TOTAL_BITS     = 32;
    localparam int LANES_MAX      = 4;
    localparam int COST_BITS      = 16;
    localparam int TIME_BITS      = 16;
    localparam int OUT_BITS       = 32;
    localparam int CFG_DATA_BITS  = 64;
    localparam int CFG_INDEX_BITS = 3;
    localparam int LANE_CNT_BITS  = 3;
    localparam int SUM_BITS       = TOTAL_BITS + 1;
    localparam int ACC_BITS       = TOTAL_BITS + 2;
    localparam int CMP_BITS       = (TOTAL_BITS > OUT_BITS) ? TOTAL_BITS : OUT_BITS;

    typedef logic [TOTAL_BITS-1:0]    total_t;
    typedef logic [COST_BITS-1:0]     cost_t;
    typedef logic [TIME_BITS-1:0]     time_t;
    typedef logic [OUT_BITS-1:0]      out_t;
    typedef logic [SUM_BITS-1:0]      sum_t;
    typedef logic [ACC_BITS-1:0]      acc_t;
    typedef logic [CMP_BITS-1:0]      cmp_t;
    typedef logic [CFG_DATA_BITS-1:0] cfg_data_t;
    typedef logic [LANE_CNT_BITS-1:0] lane_cnt_t;
    typedef logic [MACHINES-1:0]      lane_mask_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MACHINES_USED = 3'd0,
        REG_SWITCH_ROW_0  = 3'd1,
        REG_SWITCH_ROW_1  = 3'd2,
        REG_SWITCH_ROW_2  = 3'd3,
        REG_SWITCH_ROW_3  = 3'd4
    } cfg_reg_e;

    localparam lane_cnt_t MACHINES_USED_RESET = 3'd3;
    localparam cfg_data_t SWITCH_ROW_RESET [LANES_MAX] = '{
        64'd12885032960,
        64'd17179869186,
        64'd262147,
        64'd0
    };

    typedef struct packed {
        logic       first;
        logic       active;
        lane_mask_t mask;
    } lane_ctl_t;

    typedef struct packed {
        logic       load;
        logic       overflow;
        lane_mask_t mask;
    } merge_ctl_t;

endpackage

// ===== rtl/min_plus_machine_assignment_dp.sv =====
// ----------------------------------------------------------------------------
// min_plus_machine_assignment_dp
// Running min-plus totals per machine over a job stream; minimum total on the
// job flagged last.
// ----------------------------------------------------------------------------
// Throughput: one job beat per cycle while the input is not stalled; the lane
//   add-compare-select updates all machine totals in the cycle the job is accepted.
// Result path: totals and the pending flag register on the edge that accepts the
//   last job; the minimum then merges into the output register once that register
//   is empty or its beat is being taken.
// Input stalls only while a result waits for the merge and the output is held.
// Reset: totals and overflow cleared, configuration to its default values.
// ----------------------------------------------------------------------------
module min_plus_machine_assignment_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mpad_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  mpad_pkg::cfg_data_t           cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          first_job,
    input  logic                          last_job,
    input  mpad_pkg::time_t               time_m0,
    input  mpad_pkg::time_t               time_m1,
    input  mpad_pkg::time_t               time_m2,
    input  mpad_pkg::time_t               time_m3,
    output logic                          out_valid,
    input  logic                          out_stall,
    output mpad_pkg::out_t                min_total,
    output logic                          saturated
);
    import mpad_pkg::*;

    lane_cnt_t                    machines_used_reg;
    cfg_data_t                    switch_rows_reg [LANES_MAX];
    total_t    [MACHINES-1:0]     best_totals_reg;
    total_t    [MACHINES-1:0]     best_totals_next;
    logic                         overflow_reg;
    logic                         overflow_next;
    logic                         pending_reg;
    logic      [MACHINES-1:0]     lane_sat;
    lane_mask_t                   mask;
    time_t                        times [LANES_MAX];
    logic                         in_fire;
    logic                         merge_ready;
    merge_ctl_t                   merge_ctl;

    assign times[0] = time_m0;
    assign times[1] = time_m1;
    assign times[2] = time_m2;
    assign times[3] = time_m3;

    always_comb
    begin
        for (int j = 0; j < MACHINES; j++)
        begin
            mask[j] = (j == 0) || (LANE_CNT_BITS'(j) < machines_used_reg);
        end
    end

    for (genvar j = 0; j < MACHINES; j++) begin : g_lane
        cost_t     [MACHINES-1:0] column;
        lane_ctl_t                ctl;

        for (genvar k = 0; k < MACHINES; k++) begin : g_col
            assign column[k] = switch_rows_reg[k][COST_BITS*j +: COST_BITS];
        end

        assign ctl.first  = first_job;
        assign ctl.active = mask[j];
        assign ctl.mask   = mask;

        mpad_lane u_lane (
            .prev_totals (best_totals_reg),
            .costs       (column),
            .job_time    (times[j]),
            .ctl         (ctl),
            .next_total  (best_totals_next[j]),
            .sat         (lane_sat[j])
        );
    end

    assign in_stall      = pending_reg && !merge_ready;
    assign in_fire       = in_valid && !in_stall;
    assign overflow_next = (overflow_reg && !first_job) || (|lane_sat);

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            machines_used_reg <= MACHINES_USED_RESET;
            for (int k = 0; k < LANES_MAX; k++)
            begin
                switch_rows_reg[k] <= SWITCH_ROW_RESET[k];
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_e'(cfg_index))
                REG_MACHINES_USED: machines_used_reg  <= cfg_data[LANE_CNT_BITS-1:0];
                REG_SWITCH_ROW_0:  switch_rows_reg[0] <= cfg_data;
                REG_SWITCH_ROW_1:  switch_rows_reg[1] <= cfg_data;
                REG_SWITCH_ROW_2:  switch_rows_reg[2] <= cfg_data;
                REG_SWITCH_ROW_3:  switch_rows_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // totals and result hand-off
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_totals_reg <= '0;
            overflow_reg    <= 1'b0;
            pending_reg     <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                best_totals_reg <= best_totals_next;
                overflow_reg    <= overflow_next;
            end
            if (in_fire)
            begin
                pending_reg <= last_job;
            end
            else if (merge_ready)
            begin
                pending_reg <= 1'b0;
            end
        end
    end

    assign merge_ctl.load     = pending_reg;
    assign merge_ctl.overflow = overflow_reg;
    assign merge_ctl.mask     = mask;

    mpad_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (merge_ctl),
        .totals    (best_totals_reg),
        .ready     (merge_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .min_total (min_total),
        .saturated (saturated)
    );

    a_last_pends : assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && last_job |=> pending_reg)
        else $error("last job did not raise pending result");

    a_pending_moves : assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg && merge_ready |=> out_valid)
        else $error("pending result not loaded into output register");

    a_first_clears_ovf : assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && first_job && !(|lane_sat) |=> !overflow_reg)
        else $error("overflow not cleared by first job");

    a_unused_zero : assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !mask[MACHINES-1] |=> best_totals_reg[MACHINES-1] == '0)
        else $error("unused lane total not zero");

endmodule

// ===== rtl/mpad_lane.sv =====
// ----------------------------------------------------------------------------
// mpad_lane
// Add-compare-select for one machine: best previous total plus switch cost,
// plus the job time (the job time alone on a first job), saturated at the total
// limit; zero when the lane is not in use.
module mpad_lane (
    input  mpad_pkg::total_t [mpad_pkg::MACHINES-1:0] prev_totals,
    input  mpad_pkg::cost_t  [mpad_pkg::MACHINES-1:0] costs,
    input  mpad_pkg::time_t                           job_time,
    input  mpad_pkg::lane_ctl_t                       ctl,
    output mpad_pkg::total_t                          next_total,
    output logic                                      sat
);
    import mpad_pkg::*;

    sum_t cand [MACHINES];
    sum_t best;
    acc_t acc;
    total_t clamped;

    for (genvar k = 0; k < MACHINES; k++) begin : g_cand
        assign cand[k] = {1'b0, prev_totals[k]} + SUM_BITS'(costs[k]);
    end

    always_comb
    begin
        best = cand[0];
        for (int k = 1; k < MACHINES; k++)
        begin
            if (ctl.mask[k] && (cand[k] < best))
            begin
                best = cand[k];
            end
        end
    end

    always_comb
    begin
        if (ctl.first)
        begin
            acc = ACC_BITS'(job_time);
        end
        else
        begin
            acc = ACC_BITS'(best) + ACC_BITS'(job_time);
        end
        if (acc > ACC_BITS'({TOTAL_BITS{1'b1}}))
        begin
            clamped = '1;
        end
        else
        begin
            clamped = acc[TOTAL_BITS-1:0];
        end
    end

    assign next_total = ctl.active ? clamped : '0;
    assign sat        = ctl.active && (clamped == '1);

endmodule

// ===== rtl/mpad_merge.sv =====
// ----------------------------------------------------------------------------
// mpad_merge
// Minimum over the lanes in use, clamped to the output width, held in the
// output register until the beat is taken.
// ----------------------------------------------------------------------------
module mpad_merge (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  mpad_pkg::merge_ctl_t                      ctl,
    input  mpad_pkg::total_t [mpad_pkg::MACHINES-1:0] totals,
    output logic                                      ready,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output mpad_pkg::out_t                            min_total,
    output logic                                      saturated
);
    import mpad_pkg::*;

    total_t m;
    cmp_t   m_ext;
    out_t   m_out;
    logic   out_valid_reg;
    out_t   min_total_reg;
    logic   saturated_reg;

    always_comb
    begin
        m = totals[0];
        for (int k = 1; k < MACHINES; k++)
        begin
            if (ctl.mask[k] && (totals[k] < m))
            begin
                m = totals[k];
            end
        end
        m_ext = CMP_BITS'(m);
        if (m_ext > CMP_BITS'({OUT_BITS{1'b1}}))
        begin
            m_out = '1;
        end
        else
        begin
            m_out = m_ext[OUT_BITS-1:0];
        end
    end

    assign ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            out_valid_reg <= ctl.load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && ctl.load)
        begin
            min_total_reg <= m_out;
            saturated_reg <= ctl.overflow;
        end
    end

    assign out_valid = out_valid_reg;
    assign min_total = min_total_reg;
    assign saturated = saturated_reg;

endmodule

// ===== dv/mpad_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpad_checker
// Tracks the min-plus schedule of every job beat and checks each result beat.
// It mirrors the register writes, keeps its own running total per machine
// lane with saturation and the sticky overflow flag, queues the expected
// minimum total for every job flagged last and compares each accepted result
// beat field by field against the oldest entry.
// ----------------------------------------------------------------------------
module mpad_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mpad_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  mpad_pkg::cfg_data_t                 cfg_data,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                first_job,
    input  logic                                last_job,
    input  mpad_pkg::time_t                     time_m0,
    input  mpad_pkg::time_t                     time_m1,
    input  mpad_pkg::time_t                     time_m2,
    input  mpad_pkg::time_t                     time_m3,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  mpad_pkg::out_t                      min_total,
    input  logic                                saturated,
    output int                                  error_count,
    output int                                  pending,
    output int                                  jobs_seen,
    output int                                  results_seen,
    output int                                  saturated_seen
);
    import mpad_pkg::*;

    localparam logic [63:0] TOTAL_LIMIT = (64'd1 << TOTAL_BITS) - 64'd1;
    localparam logic [63:0] OUT_LIMIT   = (64'd1 << OUT_BITS) - 64'd1;
    localparam cfg_data_t   ROW0_RESET  = 64'd12885032960;
    localparam cfg_data_t   ROW1_RESET  = 64'd17179869186;
    localparam cfg_data_t   ROW2_RESET  = 64'd262147;
    localparam cfg_data_t   ROW3_RESET  = 64'd0;

    typedef struct {
        out_t min_total;
        logic saturated;
    } schedule_result_t;

    schedule_result_t schedule_q[$];
    lane_cnt_t        machines_cfg;
    cfg_data_t        switch_rows [LANES_MAX];
    total_t           lane_totals [LANES_MAX];
    logic             overflow_flag;
    int               errs;
    int               jobs;
    int               results;
    int               sat_results;

    function automatic int lanes_active();
        int n;
        n = int'(machines_cfg);
        if (n < 1)
            n = 1;
        if (n > MACHINES)
            n = MACHINES;
        return n;
    endfunction

    task automatic apply_register(input logic [CFG_INDEX_BITS-1:0] idx, input cfg_data_t data);
        case (idx)
            REG_MACHINES_USED: machines_cfg = data[LANE_CNT_BITS-1:0];
            REG_SWITCH_ROW_0:  switch_rows[0] = data;
            REG_SWITCH_ROW_1:  switch_rows[1] = data;
            REG_SWITCH_ROW_2:  switch_rows[2] = data;
            REG_SWITCH_ROW_3:  switch_rows[3] = data;
            default:           ;
        endcase
    endtask

    task automatic schedule_job(input logic first, input logic last,
                                input time_t t0, input time_t t1,
                                input time_t t2, input time_t t3);
        time_t            times [LANES_MAX];
        logic [63:0]      next_tot [LANES_MAX];
        logic [63:0]      best;
        logic [63:0]      cand;
        logic [63:0]      low;
        int               n;
        schedule_result_t res;
        times = '{t0, t1, t2, t3};
        n = lanes_active();
        if (first)
            overflow_flag = 1'b0;
        for (int j = 0; j < LANES_MAX; j++)
        begin
            if (j >= n)
            begin
                next_tot[j] = '0;
            end
            else
            begin
                if (first)
                begin
                    next_tot[j] = 64'(times[j]);
                end
                else
                begin
                    best = '1;
                    for (int k = 0; k < n; k++)
                    begin
                        cand = 64'(lane_totals[k]) + 64'(switch_rows[k][16*j +: COST_BITS]);
                        if (cand < best)
                            best = cand;
                    end
                    next_tot[j] = best + 64'(times[j]);
                end
                if (next_tot[j] > TOTAL_LIMIT)
                    next_tot[j] = TOTAL_LIMIT;
                if (next_tot[j] == TOTAL_LIMIT)
                    overflow_flag = 1'b1;
            end
        end
        for (int j = 0; j < LANES_MAX; j++)
            lane_totals[j] = total_t'(next_tot[j]);
        if (last)
        begin
            low = 64'(lane_totals[0]);
            for (int j = 1; j < n; j++)
                if (64'(lane_totals[j]) < low)
                    low = 64'(lane_totals[j]);
            if (low > OUT_LIMIT)
                low = OUT_LIMIT;
            res.min_total = out_t'(low);
            res.saturated = overflow_flag;
            schedule_q.push_back(res);
        end
    endtask

    task automatic check_result();
        schedule_result_t want;
        results++;
        if (saturated === 1'b1)
            sat_results++;
        if (schedule_q.size() == 0)
        begin
            $error("result beat with nothing expected: min_total=%0d saturated=%0b",
                   min_total, saturated);
            errs++;
        end
        else
        begin
            want = schedule_q.pop_front();
            if (min_total !== want.min_total)
            begin
                $error("min_total: expected %0d, actual %0d", want.min_total, min_total);
                errs++;
            end
            if (saturated !== want.saturated)
            begin
                $error("saturated: expected %0b, actual %0b", want.saturated, saturated);
                errs++;
            end
        end
    endtask

    initial
    begin
        errs        = 0;
        jobs        = 0;
        results     = 0;
        sat_results = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            machines_cfg   = MACHINES_USED_RESET;
            switch_rows[0] = ROW0_RESET;
            switch_rows[1] = ROW1_RESET;
            switch_rows[2] = ROW2_RESET;
            switch_rows[3] = ROW3_RESET;
            for (int r = 0; r < LANES_MAX; r++)
                lane_totals[r] = '0;
            overflow_flag = 1'b0;
            schedule_q.delete();
        end
        else
        begin
            if (cfg_we)
                apply_register(cfg_index, cfg_data);
            if (out_valid && !out_stall)
                check_result();
            if (in_valid && !in_stall)
            begin
                jobs++;
                schedule_job(first_job, last_job, time_m0, time_m1, time_m2, time_m3);
            end
        end
        pending        <= schedule_q.size();
        error_count    <= errs;
        jobs_seen      <= jobs;
        results_seen   <= results;
        saturated_seen <= sat_results;
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for min_plus_machine_assignment_dp.
// Runs a short directed set at reset settings, a short worst-case soak, then
// random job sequences over several register settings with random idling on
// both channels; a separate checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;
    import mpad_pkg::*;

    localparam int PHASES        = 8;
    localparam int PHASE_JOBS    = 130;
    localparam int SOAK_JOBS     = 100;
    localparam int DRAIN_CYCLES  = 6;
    localparam int MAX_GAP       = 13;
    localparam int LANE_PLAN [PHASES] = '{1, 4, 0, 7, 2, 3, 5, 6};

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    cfg_data_t                 cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic                      first_job;
    logic                      last_job;
    time_t                     time_m0;
    time_t                     time_m1;
    time_t                     time_m2;
    time_t                     time_m3;
    logic                      out_valid;
    logic                      out_stall;
    out_t                      min_total;
    logic                      saturated;
    int                        error_count;
    int                        pending;
    int                        jobs_seen;
    int                        results_seen;
    int                        saturated_seen;
    bit                        calm = 1'b0;

    always #4 clk = ~clk;

    min_plus_machine_assignment_dp uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .first_job (first_job),
        .last_job  (last_job),
        .time_m0   (time_m0),
        .time_m1   (time_m1),
        .time_m2   (time_m2),
        .time_m3   (time_m3),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .min_total (min_total),
        .saturated (saturated)
    );

    mpad_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .first_job      (first_job),
        .last_job       (last_job),
        .time_m0        (time_m0),
        .time_m1        (time_m1),
        .time_m2        (time_m2),
        .time_m3        (time_m3),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .min_total      (min_total),
        .saturated      (saturated),
        .error_count    (error_count),
        .pending        (pending),
        .jobs_seen      (jobs_seen),
        .results_seen   (results_seen),
        .saturated_seen (saturated_seen)
    );

    function automatic time_t pick_time();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return time_t'($urandom_range(0, 15));
            default: return time_t'($urandom);
        endcase
    endfunction

    function automatic cfg_data_t pick_row();
        return {pick_time(), pick_time(), pick_time(), pick_time()};
    endfunction

    task automatic send_job(input logic first, input logic last,
                            input time_t t0, input time_t t1,
                            input time_t t2, input time_t t3);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        first_job <= first;
        last_job  <= last;
        time_m0   <= t0;
        time_m1   <= t1;
        time_m2   <= t2;
        time_m3   <= t3;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input cfg_data_t val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input int lanes, input int row_mode);
        cfg_data_t                 word;
        logic [CFG_INDEX_BITS-1:0] spare_index;
        word = {$urandom, $urandom};
        word[LANE_CNT_BITS-1:0] = LANE_CNT_BITS'(lanes);
        write_reg(REG_MACHINES_USED, word);
        for (int r = 0; r < LANES_MAX; r++)
        begin
            case (row_mode)
                0:       word = '0;
                1:       word = '1;
                default: word = pick_row();
            endcase
            write_reg(CFG_INDEX_BITS'(int'(REG_SWITCH_ROW_0) + r), word);
        end
        spare_index = CFG_INDEX_BITS'($urandom_range(int'(REG_SWITCH_ROW_3) + 1,
                                                     (1 << CFG_INDEX_BITS) - 1));
        write_reg(spare_index, {$urandom, $urandom});
    endtask

    task automatic random_phase(input int budget);
        int sent;
        int len;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                begin
                    send_job(i == 0, i == len - 1,
                             pick_time(), pick_time(), pick_time(), pick_time());
                    sent++;
                end
            end
            else
            begin
                send_job(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         pick_time(), pick_time(), pick_time(), pick_time());
                sent++;
            end
            if ($urandom_range(0, 29) == 0)
                calm = ~calm;
        end
    endtask

    initial
    begin
        int hold;
        out_stall <= 1'b1;
        @(posedge rst_n);
        forever
        begin
            hold = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        first_job <= 1'b0;
        last_job  <= 1'b0;
        time_m0   <= '0;
        time_m1   <= '0;
        time_m2   <= '0;
        time_m3   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: job with no sequence start, then first/last corners
        send_job(1'b0, 1'b1, 16'd7, 16'd1, 16'd3, 16'd9);
        send_job(1'b1, 1'b1, 16'd5, 16'd9, 16'd2, 16'd7);
        send_job(1'b1, 1'b1, '1, '1, '1, '1);
        send_job(1'b1, 1'b1, '0, '0, '0, '0);
        send_job(1'b1, 1'b0, 16'd1, 16'd2, 16'd3, 16'd4);
        send_job(1'b0, 1'b0, '1, '0, '1, '0);
        send_job(1'b0, 1'b1, '0, '1, '0, '1);
        send_job(1'b1, 1'b0, 16'd10, 16'd20, 16'd30, 16'd40);
        send_job(1'b1, 1'b0, 16'd40, 16'd30, 16'd20, 16'd10);
        send_job(1'b0, 1'b0, 16'd3, '1, 16'd0, 16'd5);
        send_job(1'b0, 1'b1, 16'd2, 16'd2, '1, 16'd8);
        send_job(1'b0, 1'b0, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00);
        send_job(1'b0, 1'b1, 16'hAAAA, 16'h5555, 16'hFF00, 16'h00FF);
        drain();

        // worst-case soak: largest costs and times, no idling
        configure(MACHINES, 1);
        calm = 1'b1;
        send_job(1'b1, 1'b0, '1, '1, '1, '1);
        for (int i = 0; i < SOAK_JOBS; i++)
            send_job(1'b0, i == SOAK_JOBS - 1, '1, '1, '1, '1);
        send_job(1'b0, 1'b1, '0, '0, '0, '0);
        send_job(1'b1, 1'b1, '1, '1, '1, '1);
        calm = 1'b0;
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            configure(LANE_PLAN[p], (p < 2) ? p : 2);
            random_phase(PHASE_JOBS);
            drain();
        end

        $display("Run covered %0d job beats and %0d result beats (%0d saturated)",
                 jobs_seen, results_seen, saturated_seen);
        $display("across reset settings plus %0d register settings", PHASES + 1);
        if (error_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
